// ===== rtl/pts_pkg.sv =====
`default_nettype none
package pts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_OUT       = 16;
    localparam int NOUT_W        = $clog2(MAX_OUT + 1);

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_DISPATCH = 3'd4;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_DONE  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  task_tag;
        logic [31:0] start_delay;
        logic [31:0] reload_period;
        logic [3:0]  slot_index;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [7:0] tag_out;
        logic       last;
    } t_res;

    typedef struct packed {
        logic        used;
        logic [7:0]  tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } t_slot;

    typedef struct packed {
        logic [2:0] op;
        logic       idx_hit;
        logic       have;
        logic       can_emit;
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/pts_cell.sv =====
`default_nettype none
module pts_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire pts_pkg::t_slot i_slot,
    output pts_pkg::t_slot     o_slot
);
    import pts_pkg::*;

    logic  r_used;
    t_slot r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_shift) begin
            r_used <= i_slot.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_slot;
        end
    end

    always_comb begin
        o_slot      = r_data;
        o_slot.used = r_used;
    end
endmodule
`default_nettype wire

// ===== rtl/pts_head.sv =====
`default_nettype none
module pts_head (
    input  wire pts_pkg::t_slot i_slot,
    input  wire pts_pkg::t_cmd  i_cmd,
    input  wire pts_pkg::t_ctl  i_ctl,
    output pts_pkg::t_slot      o_slot,
    output logic                o_emit
);
    import pts_pkg::*;

    always_comb begin
        o_slot = i_slot;
        o_emit = 1'b0;
        case (i_ctl.op)
            OP_ADD: begin
                if (!i_slot.used && !i_ctl.have) begin
                    o_slot.used    = 1'b1;
                    o_slot.tag     = i_cmd.task_tag;
                    o_slot.delay   = i_cmd.start_delay;
                    o_slot.period  = i_cmd.reload_period;
                    o_slot.pending = 8'd0;
                    o_emit         = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (i_ctl.idx_hit) begin
                    o_slot.used = 1'b0;
                end
            end
            OP_CLEAR: begin
                o_slot.used = 1'b0;
            end
            OP_TICK: begin
                if (i_slot.used) begin
                    if (i_slot.delay == 32'd0) begin
                        if (i_slot.pending != 8'hFF) begin
                            o_slot.pending = i_slot.pending + 8'd1;
                        end
                        o_slot.delay = i_slot.period - 32'd1;
                    end else begin
                        o_slot.delay = i_slot.delay - 32'd1;
                    end
                end
            end
            OP_DISPATCH: begin
                if (i_slot.used && i_slot.pending != 8'd0 && i_ctl.can_emit) begin
                    o_slot.pending = i_slot.pending - 8'd1;
                    o_emit         = 1'b1;
                    if (i_slot.period == 32'd0) begin
                        o_slot.used = 1'b0;
                    end
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/periodic_task_scheduler_core.sv =====
// A command holds busy high from accept until its closing word is issued.
// The slot ring rotates one cell per cycle past a single update unit; a final
// state issues the closing word, on the ports in the first cycle busy is low.
// A new command is taken only while busy is low; results cannot be stalled.
// Dispatch words come one per cycle at most, the closing word marked last.
// Synchronous active-low reset frees all slots and idles the block.
`default_nettype none
module periodic_task_scheduler_core #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pts_pkg::t_cmd i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    output pts_pkg::t_res      o_result
);
    import pts_pkg::*;

    localparam int CW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MW = (CW > 4) ? CW : 4;

    logic              r_busy, n_busy;
    logic              r_fin, n_fin;
    logic              r_vld, n_vld;
    logic              r_have, n_have;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [NOUT_W-1:0] r_nout, n_nout;
    t_cmd              r_cmd, n_cmd;
    t_res              r_hold, n_hold;
    t_res              r_out, n_out;

    t_slot w_ring [NUM_SLOTS];
    t_slot w_head;
    logic  w_emit;
    logic  w_shift;
    t_ctl  w_ctl;
    t_res  w_new;

    assign w_shift = r_busy && !r_fin;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            if (g == NUM_SLOTS - 1) begin : g_tail
                pts_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_shift(w_shift),
                    .i_slot (w_head),
                    .o_slot (w_ring[g])
                );
            end else begin : g_mid
                pts_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_shift(w_shift),
                    .i_slot (w_ring[g+1]),
                    .o_slot (w_ring[g])
                );
            end
        end
    endgenerate

    always_comb begin
        w_ctl.op       = r_cmd.operation;
        w_ctl.idx_hit  = (MW'(r_cmd.slot_index) == MW'(r_cnt));
        w_ctl.have     = r_have;
        w_ctl.can_emit = (r_nout < NOUT_W'(MAX_OUT));
    end

    pts_head u_head (
        .i_slot(w_ring[0]),
        .i_cmd (r_cmd),
        .i_ctl (w_ctl),
        .o_slot(w_head),
        .o_emit(w_emit)
    );

    always_comb begin
        w_new.status  = (r_cmd.operation == OP_ADD) ? ST_ADDED : ST_RUN;
        w_new.slot    = 4'(r_cnt);
        w_new.tag_out = (r_cmd.operation == OP_ADD) ? 8'd0 : w_ring[0].tag;
        w_new.last    = 1'b0;
    end

    always_comb begin
        n_busy = r_busy;
        n_fin  = r_fin;
        n_vld  = 1'b0;
        n_have = r_have;
        n_cnt  = r_cnt;
        n_nout = r_nout;
        n_cmd  = r_cmd;
        n_hold = r_hold;
        n_out  = r_out;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_fin  = 1'b0;
                n_cnt  = '0;
                n_cmd  = i_cmd;
                n_have = 1'b0;
                n_nout = '0;
            end
        end else if (!r_fin) begin
            if (r_cnt == CW'(NUM_SLOTS - 1)) begin
                n_cnt = '0;
                n_fin = 1'b1;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
            if (w_emit) begin
                if (r_have) begin
                    n_out = r_hold;
                    n_vld = 1'b1;
                end
                n_hold = w_new;
                n_have = 1'b1;
                n_nout = r_nout + NOUT_W'(1);
            end
        end else begin
            n_busy = 1'b0;
            n_fin  = 1'b0;
            n_vld  = 1'b1;
            if (r_have) begin
                n_out      = r_hold;
                n_out.last = 1'b1;
            end else begin
                case (r_cmd.operation)
                    OP_ADD:      n_out.status = ST_FULL;
                    OP_DISPATCH: n_out.status = ST_NONE;
                    default:     n_out.status = ST_DONE;
                endcase
                n_out.slot    = 4'd0;
                n_out.tag_out = 8'd0;
                n_out.last    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_vld  <= 1'b0;
            r_have <= 1'b0;
            r_cnt  <= '0;
            r_nout <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_vld  <= n_vld;
            r_have <= n_have;
            r_cnt  <= n_cnt;
            r_nout <= n_nout;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_vld;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== rtl/pts_checker.sv =====
`default_nettype none
module pts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire pts_pkg::t_cmd i_cmd,
    input wire logic          o_busy,
    input wire logic          o_valid,
    input wire pts_pkg::t_res o_result
);
    import pts_pkg::*;

    logic w_unused;
    assign w_unused = ^i_cmd;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accept did not start a command");

    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_valid && o_result.last))
        else $error("command ended without a last word");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> o_busy)
        else $error("non-last word outside a command");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_RUN) |-> o_result.last)
        else $error("status word not marked last");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_RUN) |-> (o_result.tag_out == 8'd0))
        else $error("tag on a non-run word");
endmodule

bind periodic_task_scheduler_core pts_checker u_pts_checker (.*);
`default_nettype wire
